### hw/rtl/obd_pkg.sv
// Shared types and constants for the adapter reply decoder.
// Character codes, phase encodings and the decimal scale helper; no dependencies.
`timescale 1ns / 1ps

package obd_pkg;

    typedef enum logic [2:0] {
        NUM_SKIP,
        NUM_SIGNED,
        NUM_INT,
        NUM_FRAC,
        NUM_DONE
    } num_phase_t;

    // "410" as the three most recent hex characters, newest in the low byte
    localparam logic [23:0] PID_PREFIX       = 24'h343130;
    localparam logic [7:0]  CHAR_SPEED_PID   = 8'h43;
    localparam logic [7:0]  CHAR_COOLANT_PID = 8'h35;
    localparam logic [7:0]  CHAR_VOLT        = 8'h56;
    localparam logic [7:0]  CHAR_PLUS        = 8'h2B;
    localparam logic [7:0]  CHAR_MINUS       = 8'h2D;
    localparam logic [7:0]  CHAR_POINT       = 8'h2E;
    localparam logic [7:0]  CHAR_SPACE       = 8'h20;
    localparam logic [7:0]  CHAR_TAB         = 8'h09;
    localparam logic [7:0]  CHAR_CR          = 8'h0D;

    localparam logic [2:0]  SPEED_SEARCH     = 3'd0;
    localparam logic [2:0]  SPEED_DONE       = 3'd5;
    localparam logic [1:0]  COOLANT_SEARCH   = 2'd0;
    localparam logic [1:0]  COOLANT_DONE     = 2'd3;

    localparam logic [15:0] MAG_CAP          = 16'd32768;
    localparam logic [15:0] POS_MAX          = 16'd32767;
    localparam logic [8:0]  COOLANT_OFFSET   = 9'd40;

    function automatic logic [9:0] pow10(input logic [1:0] n);
        logic [9:0] r;
        begin
            case (n)
                2'd0:    r = 10'd1;
                2'd1:    r = 10'd10;
                2'd2:    r = 10'd100;
                default: r = 10'd1000;
            endcase
            return r;
        end
    endfunction

endpackage

### hw/rtl/obd_response_decoder.sv
// Top level of the adapter reply decoder: input register, per-character state
// update and result register. Depends on obd_pkg.
`timescale 1ns / 1ps

// Takes one reply character per item and sustains one item per clock while
// reply_stall is low. Each item waits in the input register while the scanners
// update; the item marked end_of_reply loads the result register as it leaves
// the input register, and all scanner state clears. Only the input register and
// one result register lie between the two sides: a waiting result stalls the input
// only when the next end-of-reply character reaches the input register.
// FRACTION_DIGITS (0 to 3) sets the decimal scale of supply_centivolts.
module obd_response_decoder
    import obd_pkg::*;
#(
    parameter int FRACTION_DIGITS = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               reply_valid,
    output logic               reply_stall,
    input  logic [7:0]         reply_byte,
    input  logic               end_of_reply,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [13:0]        engine_speed,
    output logic               speed_found,
    output logic signed [8:0]  coolant_celsius,
    output logic               coolant_found,
    output logic signed [15:0] supply_centivolts,
    output logic               supply_found
);

    localparam logic [9:0] SCALE   = pow10(FRACTION_DIGITS[1:0]);
    localparam logic [2:0] FRAC_MAX = 3'(FRACTION_DIGITS);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // scanner state
    logic [23:0] recent_reg, recent_next;
    logic [2:0]  speed_phase_reg, speed_phase_next;
    logic [15:0] speed_acc_reg, speed_acc_next;
    logic [1:0]  cool_phase_reg, cool_phase_next;
    logic [7:0]  cool_acc_reg, cool_acc_next;
    num_phase_t  num_phase_reg, num_phase_next;
    logic        num_neg_reg, num_neg_next;
    logic [15:0] num_acc_reg, num_acc_next;
    logic [1:0]  frac_cnt_reg, frac_cnt_next;
    logic        volt_reg, volt_next;

    // result register
    logic        result_valid_reg;
    logic [13:0] speed_out_reg;
    logic        speed_found_reg;
    logic [8:0]  cool_out_reg;
    logic        cool_found_reg;
    logic [15:0] supply_out_reg;
    logic        supply_found_reg;

    logic        advance;
    logic        is_dec, is_hex, is_space, is_sign, is_point;
    logic [3:0]  hex_val;
    logic        prefix_hit;
    logic        take_int, take_frac;
    logic [1:0]  frac_exp;
    logic [9:0]  frac_weight;
    logic [19:0] int_sum;
    logic [16:0] frac_sum;
    logic [15:0] supply_val;

    assign advance     = in_valid_reg && (!in_last_reg || !result_valid_reg || !result_stall);
    assign reply_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!reply_stall)
        begin
            in_valid_reg <= reply_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (reply_valid && !reply_stall)
        begin
            in_byte_reg <= reply_byte;
            in_last_reg <= end_of_reply;
        end
    end

    // character classes
    always_comb
    begin
        is_dec   = (in_byte_reg >= 8'h30) && (in_byte_reg <= 8'h39);
        is_hex   = is_dec
                || ((in_byte_reg >= 8'h61) && (in_byte_reg <= 8'h66))
                || ((in_byte_reg >= 8'h41) && (in_byte_reg <= 8'h46));
        is_space = (in_byte_reg == CHAR_SPACE)
                || ((in_byte_reg >= CHAR_TAB) && (in_byte_reg <= CHAR_CR));
        is_sign  = (in_byte_reg == CHAR_PLUS) || (in_byte_reg == CHAR_MINUS);
        is_point = (in_byte_reg == CHAR_POINT);
        hex_val  = is_dec ? in_byte_reg[3:0] : in_byte_reg[3:0] + 4'd9;
    end

    // hex substream scanners
    always_comb
    begin
        prefix_hit       = (recent_reg == PID_PREFIX);
        recent_next      = recent_reg;
        speed_phase_next = speed_phase_reg;
        speed_acc_next   = speed_acc_reg;
        cool_phase_next  = cool_phase_reg;
        cool_acc_next    = cool_acc_reg;
        if (is_hex)
        begin
            recent_next = {recent_reg[15:0], in_byte_reg};
            if (speed_phase_reg == SPEED_SEARCH)
            begin
                if (prefix_hit && (in_byte_reg == CHAR_SPEED_PID))
                    speed_phase_next = 3'd1;
            end
            else if (speed_phase_reg != SPEED_DONE)
            begin
                speed_acc_next   = {speed_acc_reg[11:0], hex_val};
                speed_phase_next = speed_phase_reg + 3'd1;
            end
            if (cool_phase_reg == COOLANT_SEARCH)
            begin
                if (prefix_hit && (in_byte_reg == CHAR_COOLANT_PID))
                    cool_phase_next = 2'd1;
            end
            else if (cool_phase_reg != COOLANT_DONE)
            begin
                cool_acc_next   = {cool_acc_reg[3:0], hex_val};
                cool_phase_next = cool_phase_reg + 2'd1;
            end
        end
    end

    // leading number: phase
    always_comb
    begin
        num_phase_next = num_phase_reg;
        unique case (num_phase_reg)
            NUM_SKIP:
            begin
                if (is_space)
                    num_phase_next = NUM_SKIP;
                else if (is_sign)
                    num_phase_next = NUM_SIGNED;
                else if (is_dec)
                    num_phase_next = NUM_INT;
                else if (is_point)
                    num_phase_next = NUM_FRAC;
                else
                    num_phase_next = NUM_DONE;
            end
            NUM_SIGNED, NUM_INT:
            begin
                if (is_dec)
                    num_phase_next = NUM_INT;
                else if (is_point)
                    num_phase_next = NUM_FRAC;
                else
                    num_phase_next = NUM_DONE;
            end
            NUM_FRAC:
            begin
                if (!is_dec)
                    num_phase_next = NUM_DONE;
            end
            NUM_DONE:
                num_phase_next = NUM_DONE;
            default:
                num_phase_next = num_phase_reg;
        endcase
    end

    // leading number: magnitude, sign, fraction digits
    always_comb
    begin
        take_int    = is_dec && ((num_phase_reg == NUM_SKIP) || (num_phase_reg == NUM_SIGNED)
                                 || (num_phase_reg == NUM_INT));
        take_frac   = is_dec && (num_phase_reg == NUM_FRAC) && ({1'b0, frac_cnt_reg} < FRAC_MAX);
        frac_exp    = 2'(FRAC_MAX - 3'd1) - frac_cnt_reg;
        frac_weight = pow10(frac_exp);
        int_sum     = ({4'b0, num_acc_reg} << 3) + ({4'b0, num_acc_reg} << 1)
                    + 20'(14'(in_byte_reg[3:0] * SCALE));
        frac_sum    = {1'b0, num_acc_reg} + 17'(14'(in_byte_reg[3:0] * frac_weight));

        num_neg_next  = num_neg_reg;
        num_acc_next  = num_acc_reg;
        frac_cnt_next = frac_cnt_reg;
        if ((num_phase_reg == NUM_SKIP) && is_sign)
            num_neg_next = (in_byte_reg == CHAR_MINUS);
        if (take_int)
            num_acc_next = (int_sum > 20'(MAG_CAP)) ? MAG_CAP : int_sum[15:0];
        if (take_frac)
        begin
            frac_cnt_next = frac_cnt_reg + 2'd1;
            num_acc_next  = (frac_sum > 17'(MAG_CAP)) ? MAG_CAP : frac_sum[15:0];
        end
        volt_next = volt_reg || (in_byte_reg == CHAR_VOLT);

        if (num_neg_next)
            supply_val = 16'd0 - num_acc_next;
        else
            supply_val = (num_acc_next > POS_MAX) ? POS_MAX : num_acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg      <= '0;
            speed_phase_reg <= SPEED_SEARCH;
            speed_acc_reg   <= '0;
            cool_phase_reg  <= COOLANT_SEARCH;
            cool_acc_reg    <= '0;
            num_phase_reg   <= NUM_SKIP;
            num_neg_reg     <= 1'b0;
            num_acc_reg     <= '0;
            frac_cnt_reg    <= '0;
            volt_reg        <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                recent_reg      <= '0;
                speed_phase_reg <= SPEED_SEARCH;
                speed_acc_reg   <= '0;
                cool_phase_reg  <= COOLANT_SEARCH;
                cool_acc_reg    <= '0;
                num_phase_reg   <= NUM_SKIP;
                num_neg_reg     <= 1'b0;
                num_acc_reg     <= '0;
                frac_cnt_reg    <= '0;
                volt_reg        <= 1'b0;
            end
            else
            begin
                recent_reg      <= recent_next;
                speed_phase_reg <= speed_phase_next;
                speed_acc_reg   <= speed_acc_next;
                cool_phase_reg  <= cool_phase_next;
                cool_acc_reg    <= cool_acc_next;
                num_phase_reg   <= num_phase_next;
                num_neg_reg     <= num_neg_next;
                num_acc_reg     <= num_acc_next;
                frac_cnt_reg    <= frac_cnt_next;
                volt_reg        <= volt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            speed_found_reg  <= (speed_phase_next == SPEED_DONE);
            speed_out_reg    <= (speed_phase_next == SPEED_DONE) ? speed_acc_next[15:2] : '0;
            cool_found_reg   <= (cool_phase_next == COOLANT_DONE);
            cool_out_reg     <= (cool_phase_next == COOLANT_DONE)
                              ? ({1'b0, cool_acc_next} - COOLANT_OFFSET) : '0;
            supply_found_reg <= volt_next;
            supply_out_reg   <= volt_next ? supply_val : '0;
        end
    end

    assign result_valid      = result_valid_reg;
    assign engine_speed      = speed_out_reg;
    assign speed_found       = speed_found_reg;
    assign coolant_celsius   = cool_out_reg;
    assign coolant_found     = cool_found_reg;
    assign supply_centivolts = supply_out_reg;
    assign supply_found      = supply_found_reg;

endmodule
